/* hdl/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared widths, register indexes and the geometry record of the letterbox
// nearest-neighbor scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

   // Display and source limits
   localparam int DISP_WIDTH  = 240;
   localparam int DISP_HEIGHT = 135;
   localparam int SRC_W       = 14;              // config register width
   localparam int SRC_MAX     = 8192;            // larger sizes clamp to this
   localparam int SCOL_W      = $clog2(SRC_MAX); // source position counters

   localparam int DISP_X_W    = $clog2(DISP_WIDTH + 1);
   localparam int DISP_Y_W    = $clog2(DISP_HEIGHT + 1);
   localparam int DISP_MAX_W  = (DISP_X_W > DISP_Y_W) ? DISP_X_W : DISP_Y_W;
   localparam int PROD_W      = SRC_W + DISP_MAX_W;

   // Frame store
   localparam int STORE_DEPTH = DISP_WIDTH * DISP_HEIGHT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int IDX_W       = 15;
   localparam int WORD_W      = 16;

   // Row of a read index by reciprocal multiplication
   localparam int RECIP_SHIFT  = IDX_W + $clog2(DISP_WIDTH);
   localparam int RECIP_MULT   = (2 ** RECIP_SHIFT + DISP_WIDTH - 1) / DISP_WIDTH;
   localparam int RECIP_W      = $clog2(RECIP_MULT + 1);
   localparam int RECIP_PROD_W = IDX_W + RECIP_W;
   localparam int QY_W         = $clog2((2 ** IDX_W) / DISP_WIDTH + 1);

   // Stream payload widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   // Configuration registers
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [SRC_W-1:0] SOURCE_WIDTH_RESET  = SRC_W'(1920);
   localparam logic [SRC_W-1:0] SOURCE_HEIGHT_RESET = SRC_W'(1080);

   typedef struct packed {
      logic [DISP_X_W-1:0] active_width;
      logic [DISP_Y_W-1:0] active_height;
      logic [DISP_X_W-1:0] offset_col;
      logic [DISP_Y_W-1:0] offset_row;
      logic [SRC_W-1:0]    eff_width;
      logic [SRC_W-1:0]    eff_height;
      logic [SRC_W-1:0]    col_step_q;
      logic [DISP_X_W-1:0] col_step_r;
      logic [SRC_W-1:0]    row_step_q;
      logic [DISP_Y_W-1:0] row_step_r;
   } geometry_type;

endpackage

`default_nettype wire

/* hdl/lbs_geometry.sv */
// ----------------------------------------------------------------------------
// lbs_geometry
// Fits the source size into the display, then derives the active size, the
// centering offsets and the per-step quotient/remainder of the source
// position accumulators with one shared bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_geometry (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [lbs_pkg::SRC_W-1:0] source_width,
   input  wire logic [lbs_pkg::SRC_W-1:0] source_height,
   output logic                           busy,
   output lbs_pkg::geometry_type          geo
);
   import lbs_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_FIT,
      S_ACT_GO,
      S_ACT_WAIT,
      S_COL_GO,
      S_COL_WAIT,
      S_ROW_GO,
      S_ROW_WAIT,
      S_OFFSET
   } state_type;

   state_type           state_ff;
   logic                wide_ff;
   logic [CNT_W-1:0]    div_count_ff;
   logic [PROD_W-1:0]   div_quo_ff;
   logic [SRC_W-1:0]    div_rem_ff;
   logic [SRC_W-1:0]    div_divisor_ff;
   geometry_type        geo_ff;

   logic [SRC_W:0]      div_shift;
   logic [SRC_W:0]      div_diff;
   logic                div_ge;
   logic [PROD_W-1:0]   div_quo_in;
   logic [SRC_W-1:0]    div_rem_in;
   logic                div_last;
   logic [PROD_W-1:0]   width_prod;
   logic [PROD_W-1:0]   height_prod;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      div_shift  = {div_rem_ff, div_quo_ff[PROD_W-1]};
      div_diff   = div_shift - {1'b0, div_divisor_ff};
      div_ge     = (div_shift >= {1'b0, div_divisor_ff});
      div_rem_in = div_ge ? div_diff[SRC_W-1:0] : div_shift[SRC_W-1:0];
      div_quo_in = {div_quo_ff[PROD_W-2:0], div_ge};
      div_last   = (div_count_ff == '0);
   end

   assign width_prod  = PROD_W'(geo_ff.eff_width) * PROD_W'(DISP_HEIGHT);
   assign height_prod = PROD_W'(DISP_WIDTH) * PROD_W'(geo_ff.eff_height);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else if (start) begin
         state_ff <= S_LOAD;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               state_ff <= S_IDLE;
            end
            S_LOAD: begin
               geo_ff.eff_width  <= (source_width > SRC_W'(SRC_MAX)) ?
                                    SRC_W'(SRC_MAX) : source_width;
               geo_ff.eff_height <= (source_height > SRC_W'(SRC_MAX)) ?
                                    SRC_W'(SRC_MAX) : source_height;
               state_ff <= S_FIT;
            end
            S_FIT: begin
               wide_ff <= (width_prod > height_prod);
               if (geo_ff.eff_width == '0 || geo_ff.eff_height == '0) begin
                  geo_ff.active_width  <= '0;
                  geo_ff.active_height <= '0;
                  geo_ff.col_step_q    <= '0;
                  geo_ff.col_step_r    <= '0;
                  geo_ff.row_step_q    <= '0;
                  geo_ff.row_step_r    <= '0;
                  state_ff <= S_OFFSET;
               end else begin
                  state_ff <= S_ACT_GO;
               end
            end
            S_ACT_GO: begin
               div_quo_ff     <= wide_ff ? height_prod : width_prod;
               div_divisor_ff <= wide_ff ? geo_ff.eff_width : geo_ff.eff_height;
               div_rem_ff     <= '0;
               div_count_ff   <= CNT_W'(PROD_W - 1);
               state_ff       <= S_ACT_WAIT;
            end
            S_ACT_WAIT: begin
               div_quo_ff   <= div_quo_in;
               div_rem_ff   <= div_rem_in;
               div_count_ff <= div_count_ff - CNT_W'(1);
               if (div_last) begin
                  if (wide_ff) begin
                     geo_ff.active_width  <= DISP_X_W'(DISP_WIDTH);
                     geo_ff.active_height <= div_quo_in[DISP_Y_W-1:0];
                  end else begin
                     geo_ff.active_height <= DISP_Y_W'(DISP_HEIGHT);
                     geo_ff.active_width  <= div_quo_in[DISP_X_W-1:0];
                  end
                  state_ff <= S_COL_GO;
               end
            end
            S_COL_GO: begin
               if (geo_ff.active_width == '0) begin
                  geo_ff.col_step_q <= '0;
                  geo_ff.col_step_r <= '0;
                  state_ff <= S_ROW_GO;
               end else begin
                  div_quo_ff     <= PROD_W'(geo_ff.eff_width);
                  div_divisor_ff <= SRC_W'(geo_ff.active_width);
                  div_rem_ff     <= '0;
                  div_count_ff   <= CNT_W'(PROD_W - 1);
                  state_ff       <= S_COL_WAIT;
               end
            end
            S_COL_WAIT: begin
               div_quo_ff   <= div_quo_in;
               div_rem_ff   <= div_rem_in;
               div_count_ff <= div_count_ff - CNT_W'(1);
               if (div_last) begin
                  geo_ff.col_step_q <= div_quo_in[SRC_W-1:0];
                  geo_ff.col_step_r <= div_rem_in[DISP_X_W-1:0];
                  state_ff <= S_ROW_GO;
               end
            end
            S_ROW_GO: begin
               if (geo_ff.active_height == '0) begin
                  geo_ff.row_step_q <= '0;
                  geo_ff.row_step_r <= '0;
                  state_ff <= S_OFFSET;
               end else begin
                  div_quo_ff     <= PROD_W'(geo_ff.eff_height);
                  div_divisor_ff <= SRC_W'(geo_ff.active_height);
                  div_rem_ff     <= '0;
                  div_count_ff   <= CNT_W'(PROD_W - 1);
                  state_ff       <= S_ROW_WAIT;
               end
            end
            S_ROW_WAIT: begin
               div_quo_ff   <= div_quo_in;
               div_rem_ff   <= div_rem_in;
               div_count_ff <= div_count_ff - CNT_W'(1);
               if (div_last) begin
                  geo_ff.row_step_q <= div_quo_in[SRC_W-1:0];
                  geo_ff.row_step_r <= div_rem_in[DISP_Y_W-1:0];
                  state_ff <= S_OFFSET;
               end
            end
            S_OFFSET: begin
               geo_ff.offset_col <= (DISP_X_W'(DISP_WIDTH) - geo_ff.active_width) >> 1;
               geo_ff.offset_row <= (DISP_Y_W'(DISP_HEIGHT) - geo_ff.active_height) >> 1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign geo  = geo_ff;

endmodule

`default_nettype wire

/* hdl/letterbox_nearest_scaler_rgb565_top.sv */
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_rgb565_top - letterbox nearest-neighbor scaler
// Throughput: one item per cycle, source pixels and frame reads alike, unless
// a geometry rebuild, a config write or a full output register holds the input.
// A frame read passes the registered store read and stage 1, then border check
// into the output register. A size write or reset occupies the serial geometry
// divider (one quotient bit per cycle, up to three divisions); no item is taken then.
// Reset (synchronous, active high) loads 1920x1080 and clears the stream
// position; the frame store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module letterbox_nearest_scaler_rgb565_top (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // Input items
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: blue[7:0], green[15:8], red[23:16], read_index[38:24], zero[39]
   input  wire logic [lbs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: mode[0], frame_start[1]
   input  wire logic [lbs_pkg::REQ_TUSER_W-1:0] req_tuser,

   // Result items
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: pixel_word[15:0]
   output logic [lbs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,

   // Configuration writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lbs_pkg::SRC_W-1:0]       csr_data
);
   import lbs_pkg::*;

   localparam int ADDR_CALC_W = DISP_Y_W + DISP_X_W + 2;
   localparam int ROW_CMP_W   = ((QY_W > DISP_Y_W) ? QY_W : DISP_Y_W) + 1;

   // ------------------------------------------------------------------------
   // Configuration registers and geometry
   // ------------------------------------------------------------------------
   logic [SRC_W-1:0] source_width_ff;
   logic [SRC_W-1:0] source_height_ff;
   logic             cfg_fire;
   logic             cfg_apply;
   logic             geo_busy;
   geometry_type     geo;

   assign csr_ready = !geo_busy;
   assign cfg_fire  = csr_valid && csr_ready;
   assign cfg_apply = cfg_fire &&
                      (csr_index == CSR_SOURCE_WIDTH || csr_index == CSR_SOURCE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= SOURCE_WIDTH_RESET;
         source_height_ff <= SOURCE_HEIGHT_RESET;
      end else if (cfg_fire) begin
         if (csr_index == CSR_SOURCE_WIDTH) begin
            source_width_ff <= csr_data;
         end else if (csr_index == CSR_SOURCE_HEIGHT) begin
            source_height_ff <= csr_data;
         end
      end
   end

   // The geometry unit picks up the new register values in the cycle after start
   lbs_geometry u_geometry (
      .clock         (clock),
      .reset         (reset),
      .start         (cfg_apply),
      .source_width  (source_width_ff),
      .source_height (source_height_ff),
      .busy          (geo_busy),
      .geo           (geo)
   );

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   logic out_free;
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic req_fire;
   logic pix_fire;
   logic rd_fire;
   logic in_mode;
   logic in_frame_start;
   logic [7:0]       in_blue;
   logic [7:0]       in_green;
   logic [7:0]       in_red;
   logic [IDX_W-1:0] in_read_index;

   assign in_mode        = req_tuser[0];
   assign in_frame_start = req_tuser[1];
   assign in_blue        = req_tdata[7:0];
   assign in_green       = req_tdata[15:8];
   assign in_red         = req_tdata[23:16];
   assign in_read_index  = req_tdata[38:24];

   // Take a new item unless geometry is being rebuilt, a config write is offered,
   // or the read stage is stuck behind a full output register.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !geo_busy && !csr_valid && (!s1_valid_ff || out_free);
   assign req_fire   = req_tvalid && req_tready;
   assign pix_fire   = req_fire && !in_mode;
   assign rd_fire    = req_fire && in_mode;

   // ------------------------------------------------------------------------
   // Stream position and source target accumulators
   // Target column = floor(next_dest_col * W / active_width) kept as
   // quotient plus remainder; each hit adds W/aw and carries the remainder.
   // ------------------------------------------------------------------------
   logic [SCOL_W-1:0]   src_col_ff,  src_col_in;
   logic [SCOL_W-1:0]   src_row_ff,  src_row_in;
   logic [DISP_X_W-1:0] dst_col_ff,  dst_col_in;
   logic [DISP_Y_W-1:0] dst_row_ff,  dst_row_in;
   logic [SRC_W-1:0]    tcol_q_ff,   tcol_q_in;
   logic [DISP_X_W-1:0] tcol_r_ff,   tcol_r_in;
   logic [SRC_W-1:0]    trow_q_ff,   trow_q_in;
   logic [DISP_Y_W-1:0] trow_r_ff,   trow_r_in;

   logic [SCOL_W-1:0]   cur_scol, cur_srow;
   logic [DISP_X_W-1:0] cur_dcol;
   logic [DISP_Y_W-1:0] cur_drow;
   logic [SRC_W-1:0]    cur_tcol_q, cur_trow_q;
   logic [DISP_X_W-1:0] cur_tcol_r;
   logic [DISP_Y_W-1:0] cur_trow_r;

   logic [DISP_X_W:0]   tcol_rsum;
   logic                tcol_carry;
   logic [SRC_W-1:0]    tcol_q_adv;
   logic [DISP_X_W-1:0] tcol_r_adv;
   logic [DISP_Y_W:0]   trow_rsum;
   logic                trow_carry;
   logic [SRC_W-1:0]    trow_q_adv;
   logic [DISP_Y_W-1:0] trow_r_adv;

   logic row_hit;
   logic col_hit;
   logic col_end;
   logic row_end;

   always_comb begin
      // A frame start takes this pixel as source (0,0)
      cur_scol   = in_frame_start ? '0 : src_col_ff;
      cur_srow   = in_frame_start ? '0 : src_row_ff;
      cur_dcol   = in_frame_start ? '0 : dst_col_ff;
      cur_drow   = in_frame_start ? '0 : dst_row_ff;
      cur_tcol_q = in_frame_start ? '0 : tcol_q_ff;
      cur_tcol_r = in_frame_start ? '0 : tcol_r_ff;
      cur_trow_q = in_frame_start ? '0 : trow_q_ff;
      cur_trow_r = in_frame_start ? '0 : trow_r_ff;

      tcol_rsum  = {1'b0, cur_tcol_r} + {1'b0, geo.col_step_r};
      tcol_carry = (tcol_rsum >= {1'b0, geo.active_width});
      tcol_r_adv = tcol_carry ? DISP_X_W'(tcol_rsum - {1'b0, geo.active_width})
                              : tcol_rsum[DISP_X_W-1:0];
      tcol_q_adv = cur_tcol_q + geo.col_step_q + SRC_W'(tcol_carry);

      trow_rsum  = {1'b0, cur_trow_r} + {1'b0, geo.row_step_r};
      trow_carry = (trow_rsum >= {1'b0, geo.active_height});
      trow_r_adv = trow_carry ? DISP_Y_W'(trow_rsum - {1'b0, geo.active_height})
                              : trow_rsum[DISP_Y_W-1:0];
      trow_q_adv = cur_trow_q + geo.row_step_q + SRC_W'(trow_carry);

      row_hit = (geo.active_height != '0) && (cur_drow < geo.active_height) &&
                (SRC_W'(cur_srow) == cur_trow_q);
      col_hit = row_hit && (geo.active_width != '0) && (cur_dcol < geo.active_width) &&
                (SRC_W'(cur_scol) == cur_tcol_q);
      col_end = (SRC_W'(cur_scol) + SRC_W'(1) >= geo.eff_width);
      row_end = (SRC_W'(cur_srow) + SRC_W'(1) >= geo.eff_height);
   end

   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      dst_col_in = dst_col_ff;
      dst_row_in = dst_row_ff;
      tcol_q_in  = tcol_q_ff;
      tcol_r_in  = tcol_r_ff;
      trow_q_in  = trow_q_ff;
      trow_r_in  = trow_r_ff;
      if (cfg_apply) begin
         // A new source size restarts the stream
         src_col_in = '0;
         src_row_in = '0;
         dst_col_in = '0;
         dst_row_in = '0;
         tcol_q_in  = '0;
         tcol_r_in  = '0;
         trow_q_in  = '0;
         trow_r_in  = '0;
      end else if (pix_fire) begin
         src_row_in = cur_srow;
         dst_row_in = cur_drow;
         trow_q_in  = cur_trow_q;
         trow_r_in  = cur_trow_r;
         if (col_end) begin
            src_col_in = '0;
            dst_col_in = '0;
            tcol_q_in  = '0;
            tcol_r_in  = '0;
            if (row_hit) begin
               dst_row_in = cur_drow + DISP_Y_W'(1);
               trow_q_in  = trow_q_adv;
               trow_r_in  = trow_r_adv;
            end
            if (row_end) begin
               src_row_in = '0;
               dst_row_in = '0;
               trow_q_in  = '0;
               trow_r_in  = '0;
            end else begin
               src_row_in = cur_srow + SCOL_W'(1);
            end
         end else begin
            src_col_in = cur_scol + SCOL_W'(1);
            dst_col_in = cur_dcol;
            tcol_q_in  = cur_tcol_q;
            tcol_r_in  = cur_tcol_r;
            if (col_hit) begin
               dst_col_in = cur_dcol + DISP_X_W'(1);
               tcol_q_in  = tcol_q_adv;
               tcol_r_in  = tcol_r_adv;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
         tcol_q_ff  <= '0;
         tcol_r_ff  <= '0;
         trow_q_ff  <= '0;
         trow_r_ff  <= '0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         dst_col_ff <= dst_col_in;
         dst_row_ff <= dst_row_in;
         tcol_q_ff  <= tcol_q_in;
         tcol_r_ff  <= tcol_r_in;
         trow_q_ff  <= trow_q_in;
         trow_r_ff  <= trow_r_in;
      end
   end

   // ------------------------------------------------------------------------
   // Frame store write: byte-swapped RGB565 at the current display pixel
   // ------------------------------------------------------------------------
   logic [DISP_Y_W:0]      wr_row;
   logic [DISP_X_W:0]      wr_col;
   logic [ADDR_CALC_W-1:0] wr_addr_full;
   logic                   store_we;
   logic [STORE_AW-1:0]    store_wa;
   logic [WORD_W-1:0]      store_wd;

   assign wr_row       = {1'b0, geo.offset_row} + {1'b0, cur_drow};
   assign wr_col       = {1'b0, geo.offset_col} + {1'b0, cur_dcol};
   assign wr_addr_full = ADDR_CALC_W'(wr_row) * ADDR_CALC_W'(DISP_WIDTH)
                       + ADDR_CALC_W'(wr_col);
   assign store_we     = pix_fire && col_hit &&
                         (wr_addr_full < ADDR_CALC_W'(STORE_DEPTH));
   assign store_wa     = wr_addr_full[STORE_AW-1:0];
   // RGB565 is {r[7:3], g[7:2], b[7:3]}; drive the low byte first
   assign store_wd     = {in_green[4:2], in_blue[7:3], in_red[7:3], in_green[7:5]};

   // ------------------------------------------------------------------------
   // Frame store memory. A read item never shares a cycle with a write, and
   // a write lands before any later read, so no forwarding is needed.
   // ------------------------------------------------------------------------
   logic [WORD_W-1:0] store_mem [STORE_DEPTH];
   logic [WORD_W-1:0] store_rd_ff;
   logic              rd_in_range;

   assign rd_in_range = (in_read_index < IDX_W'(STORE_DEPTH));

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      if (rd_fire && rd_in_range) begin
         store_rd_ff <= store_mem[in_read_index[STORE_AW-1:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Read stage 1: row of the index by reciprocal multiplication
   // ------------------------------------------------------------------------
   logic [RECIP_PROD_W-1:0] rd_prod;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic [QY_W-1:0]         s1_row_ff;
   logic                    s1_valid_in;

   assign rd_prod     = RECIP_PROD_W'(in_read_index) * RECIP_PROD_W'(RECIP_MULT);
   assign s1_valid_in = rd_fire ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (rd_fire) begin
         s1_idx_ff <= in_read_index;
         s1_row_ff <= rd_prod[RECIP_SHIFT +: QY_W];
      end
   end

   // ------------------------------------------------------------------------
   // Read stage 2: border check and output register
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0]    rd_col_wide;
   logic [DISP_X_W-1:0] rd_col;
   logic [ROW_CMP_W-1:0] rd_row_ext;
   logic [ROW_CMP_W-1:0] orow_ext;
   logic [ROW_CMP_W-1:0] orow_end;
   logic [DISP_X_W:0]   ocol_end;
   logic                rd_inside;
   logic [WORD_W-1:0]   rsp_word_ff;

   always_comb begin
      rd_col_wide = s1_idx_ff - IDX_W'(s1_row_ff) * IDX_W'(DISP_WIDTH);
      rd_col      = rd_col_wide[DISP_X_W-1:0];
      rd_row_ext  = ROW_CMP_W'(s1_row_ff);
      orow_ext    = ROW_CMP_W'(geo.offset_row);
      orow_end    = ROW_CMP_W'(geo.offset_row) + ROW_CMP_W'(geo.active_height);
      ocol_end    = {1'b0, geo.offset_col} + {1'b0, geo.active_width};
      rd_inside   = (s1_idx_ff < IDX_W'(STORE_DEPTH)) &&
                    (rd_col >= geo.offset_col) && ({1'b0, rd_col} < ocol_end) &&
                    (rd_row_ext >= orow_ext) && (rd_row_ext < orow_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      // Advance stage 1 into the output register; borders read black
      if (s1_valid_ff && out_free) begin
         rsp_word_ff <= rd_inside ? store_rd_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - letterbox nearest-neighbor scaler, RGB565 frame store
// Streams source pixels and frame reads into the scaler with random idling on
// both streams and a long result stall. An in-bench predictor keeps its own
// geometry, stream position and frame store, and every read answer is checked
// against it. Reads never touch an active-region word that was never written.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lbs_pkg::*;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_READ  = 1'b1;
   // No register sits at this index; a write to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED   = CSR_INDEX_W'(15);
   localparam logic [SRC_W-1:0]       SIZE_FIELD_MAX = '1;
   localparam logic [IDX_W-1:0]       INDEX_MAX      = '1;

   localparam int RANDOM_ITEMS  = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      logic             mode;
      logic             frame_start;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [IDX_W-1:0] read_index;
   } scaler_item_type;

   // --------------------------------------------------------------------------
   // Block ports, all inputs known from time zero
   // --------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [SRC_W-1:0]       csr_data   = '0;

   letterbox_nearest_scaler_rgb565_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // --------------------------------------------------------------------------
   // Predictor state: registers, fitted geometry, stream position, frame store
   // --------------------------------------------------------------------------
   logic [SRC_W-1:0]  source_w_reg;
   logic [SRC_W-1:0]  source_h_reg;
   int unsigned       fit_width;
   int unsigned       fit_height;
   int unsigned       pad_col;
   int unsigned       pad_row;
   int unsigned       src_x;
   int unsigned       src_y;
   int unsigned       dst_x;
   int unsigned       dst_y;
   logic [WORD_W-1:0] frame_words [STORE_DEPTH];
   bit                frame_written [STORE_DEPTH];
   int unsigned       written_indexes [$];
   logic [WORD_W-1:0] expected_words [$];

   int  error_count = 0;
   int  items_sent  = 0;
   int  cycle_count = 0;
   bit  gaps_on     = 1'b1;   // both sides idle at random while set
   bit  hold_request = 1'b0;  // toggle to start one long result stall
   bit  hold_seen    = 1'b0;
   int  hold_left    = 0;
   int  rsp_wait     = 0;

   function automatic int unsigned clamp_size(logic [SRC_W-1:0] size);
      return (size > SRC_MAX) ? SRC_MAX : size;
   endfunction

   function automatic void restart_position();
      src_x = 0;
      src_y = 0;
      dst_x = 0;
      dst_y = 0;
   endfunction

   // Fit the source into the display, keeping the aspect ratio, and center it
   function automatic void fit_geometry();
      int unsigned w;
      int unsigned h;
      w = clamp_size(source_w_reg);
      h = clamp_size(source_h_reg);
      if (w * DISP_HEIGHT > DISP_WIDTH * h) begin
         fit_width  = DISP_WIDTH;
         fit_height = (w != 0) ? (DISP_WIDTH * h) / w : 0;
      end else begin
         fit_height = DISP_HEIGHT;
         fit_width  = (h != 0) ? (DISP_HEIGHT * w) / h : 0;
      end
      if (w == 0 || h == 0) begin
         fit_width  = 0;
         fit_height = 0;
      end
      pad_col = (DISP_WIDTH - fit_width) / 2;
      pad_row = (DISP_HEIGHT - fit_height) / 2;
   endfunction

   function automatic bit in_active_region(int unsigned idx);
      int unsigned x;
      int unsigned y;
      x = idx % DISP_WIDTH;
      y = idx / DISP_WIDTH;
      return idx < STORE_DEPTH && x >= pad_col && x < pad_col + fit_width &&
             y >= pad_row && y < pad_row + fit_height;
   endfunction

   // Advance the stream by one source pixel, storing it when it is the
   // nearest neighbor of the next display pixel
   function automatic void scale_pixel(logic fs, logic [7:0] b, logic [7:0] g,
                                       logic [7:0] r);
      int unsigned w;
      int unsigned h;
      int unsigned addr;
      bit          row_hit;
      bit          col_hit;
      logic [15:0] rgb;
      w = clamp_size(source_w_reg);
      h = clamp_size(source_h_reg);
      if (fs)
         restart_position();
      row_hit = 1'b0;
      col_hit = 1'b0;
      if (fit_height != 0 && dst_y < fit_height)
         row_hit = (src_y == dst_y * h / fit_height);
      if (row_hit && fit_width != 0 && dst_x < fit_width)
         col_hit = (src_x == dst_x * w / fit_width);
      if (col_hit) begin
         addr = (pad_row + dst_y) * DISP_WIDTH + pad_col + dst_x;
         if (addr < STORE_DEPTH) begin
            rgb = {r[7:3], g[7:2], b[7:3]};
            frame_words[addr] = {rgb[7:0], rgb[15:8]};
            if (!frame_written[addr]) begin
               frame_written[addr] = 1'b1;
               written_indexes.insert(written_indexes.size(), addr);
            end
         end
         dst_x++;
      end
      // End of a row, and of a frame after the last row
      if (src_x + 1 >= w) begin
         src_x = 0;
         dst_x = 0;
         if (row_hit)
            dst_y++;
         if (src_y + 1 >= h) begin
            src_y = 0;
            dst_y = 0;
         end else begin
            src_y++;
         end
      end else begin
         src_x++;
      end
   endfunction

   // Pick a read index whose answer is defined: written, border or off-display
   function automatic logic [IDX_W-1:0] pick_read_index();
      int unsigned idx;
      int          tries;
      for (tries = 0; tries < 64; tries++) begin
         if (written_indexes.size() != 0 && $urandom_range(0, 2) != 0)
            idx = written_indexes[$urandom_range(0, written_indexes.size() - 1)];
         else
            idx = $urandom_range(0, 2 ** IDX_W - 1);
         if (idx >= STORE_DEPTH || !in_active_region(idx) || frame_written[idx])
            return IDX_W'(idx);
      end
      return INDEX_MAX;
   endfunction

   function automatic scaler_item_type pixel_item(logic fs, logic [7:0] b, logic [7:0] g,
                                                  logic [7:0] r);
      scaler_item_type item;
      item.mode        = MODE_PIXEL;
      item.frame_start = fs;
      item.blue        = b;
      item.green       = g;
      item.red         = r;
      item.read_index  = IDX_W'($urandom);
      return item;
   endfunction

   function automatic scaler_item_type random_pixel_item(logic fs);
      return pixel_item(fs, 8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   function automatic scaler_item_type read_item(logic [IDX_W-1:0] idx);
      scaler_item_type item;
      item.mode        = MODE_READ;
      item.frame_start = 1'($urandom);
      item.blue        = 8'($urandom);
      item.green       = 8'($urandom);
      item.red         = 8'($urandom);
      item.read_index  = idx;
      return item;
   endfunction

   // --------------------------------------------------------------------------
   // Sender: offer one item, wait for its handshake, then predict its effect.
   // Valid stays high between back-to-back items; lower it only for a gap.
   // --------------------------------------------------------------------------
   task automatic push_item(scaler_item_type item);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      // tdata: blue, green, red, read_index, zero pad
      req_tdata  <= {1'b0, item.read_index, item.red, item.green, item.blue};
      // tuser: mode, frame_start
      req_tuser  <= {item.frame_start, item.mode};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (item.mode == MODE_READ)
         expected_words.insert(expected_words.size(),
                               in_active_region(item.read_index) ?
                               frame_words[item.read_index] : '0);
      else
         scale_pixel(item.frame_start, item.blue, item.green, item.red);
      items_sent++;
   endtask

   // Drop valid, wait for every outstanding answer, then let the pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while the block is idle; mapped writes refit the
   // geometry and restart the stream position
   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [SRC_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_SOURCE_WIDTH || index == CSR_SOURCE_HEIGHT) begin
         if (index == CSR_SOURCE_WIDTH)
            source_w_reg = value;
         else
            source_h_reg = value;
         fit_geometry();
         restart_position();
      end
   endtask

   task automatic set_source_size(int unsigned w, int unsigned h);
      if ($urandom_range(0, 1)) begin
         write_register(CSR_SOURCE_WIDTH, SRC_W'(w));
         write_register(CSR_SOURCE_HEIGHT, SRC_W'(h));
      end else begin
         write_register(CSR_SOURCE_HEIGHT, SRC_W'(h));
         write_register(CSR_SOURCE_WIDTH, SRC_W'(w));
      end
   endtask

   // --------------------------------------------------------------------------
   // Receiver: check each accepted word against the oldest expectation, then
   // draw the stall before the next one. A hold request stalls for a long
   // stretch counted here.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("pixel_word: expected none, actual %h", rsp_tdata);
               error_count++;
            end else if (rsp_tdata !== expected_words[0]) begin
               $error("pixel_word: expected %h, actual %h", expected_words[0], rsp_tdata);
               error_count++;
            end
            if (expected_words.size() != 0)
               void'(expected_words.pop_front());
            rsp_wait = gaps_on ? $urandom_range(0, 3) : 0;
         end
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Reset size fills the whole display; store white (black is skipped), read the
   // written word, and read past the display at both ends of that range
   task automatic test_reset_geometry();
      push_item(pixel_item(1'b1, 8'hFF, 8'hFF, 8'hFF));
      push_item(pixel_item(1'b0, 8'h00, 8'h00, 8'h00));
      push_item(read_item('0));
      push_item(read_item(IDX_W'(STORE_DEPTH)));
      push_item(read_item(INDEX_MAX));
   endtask

   // Sizes above the limit clamp; the old word at index zero is now a border
   task automatic test_oversized_source();
      set_source_size(SIZE_FIELD_MAX, SIZE_FIELD_MAX);
      push_item(random_pixel_item(1'b1));
      push_item(random_pixel_item(1'b0));
      push_item(read_item('0));
      push_item(read_item(pick_read_index()));
   endtask

   // Zero width, then zero height: nothing is stored, every read is black
   task automatic test_empty_region();
      write_register(CSR_SOURCE_WIDTH, '0);
      repeat (3) push_item(random_pixel_item(1'($urandom)));
      push_item(read_item(pick_read_index()));
      set_source_size(5, 0);
      repeat (2) push_item(random_pixel_item(1'($urandom)));
      push_item(read_item(pick_read_index()));
   endtask

   // Upscaling sizes store at most one display pixel per source pixel
   task automatic test_upscale_skip();
      set_source_size(1, 1);
      repeat (2) push_item(random_pixel_item(1'b0));
      push_item(read_item(pick_read_index()));
      set_source_size(3, 2);
      push_item(random_pixel_item(1'b1));
      repeat (2) push_item(random_pixel_item(1'b0));
      repeat (2) push_item(read_item(pick_read_index()));
   endtask

   // Phases of random sizes, each sending random pixels (whole frames for small
   // sizes) with reads mixed in, plus cut frames and stray frame starts
   task automatic test_random_frames();
      int          phase;
      int          start_count;
      int          frames;
      int          frame_len;
      int          len;
      int          p;
      int unsigned w;
      int unsigned h;
      logic        fs;
      phase       = 0;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         // Force a size near the display, an unmapped write and a tall downscale early
         if (phase == 0)
            set_source_size($urandom_range(240, 320), $urandom_range(135, 180));
         else if (phase == 1 || $urandom_range(0, 19) == 0)
            write_register(CSR_UNMAPPED, SRC_W'($urandom));
         else if (phase == 2)
            set_source_size($urandom_range(240, 260), $urandom_range(300, SRC_MAX));
         else begin
            case ($urandom_range(0, 9))
               0: set_source_size($urandom_range(240, 320), $urandom_range(135, 180));
               1: begin
                  if ($urandom_range(0, 1))
                     write_register(CSR_SOURCE_WIDTH, SRC_W'($urandom_range(0, 24)));
                  else
                     write_register(CSR_SOURCE_HEIGHT, SRC_W'($urandom_range(0, 16)));
               end
               2: ;  // keep size and stream position
               default: set_source_size($urandom_range(0, 24), $urandom_range(0, 16));
            endcase
         end
         w = clamp_size(source_w_reg);
         h = clamp_size(source_h_reg);
         if (w > 640) begin
            frames    = 1;
            frame_len = $urandom_range(20, 200);
         end else if (w > 24 || h > 16) begin
            frames    = 1;
            frame_len = ((w == 0) ? 1 : w) * $urandom_range(1, 2);
         end else begin
            frames    = $urandom_range(1, 2);
            frame_len = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         end
         repeat (frames) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_len) : frame_len;
            for (p = 0; p < len; p++) begin
               if ($urandom_range(0, 4) == 0)
                  push_item(read_item(pick_read_index()));
               fs = (p == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 99) == 0);
               push_item(random_pixel_item(fs));
            end
         end
         repeat ($urandom_range(2, 8)) push_item(read_item(pick_read_index()));
         phase++;
      end
      gaps_on = 1'b1;
   endtask

   // Stall results for a long stretch while reads keep coming back to back,
   // so the block fills and holds its input
   task automatic test_backpressure();
      int p;
      set_source_size(16, 9);
      gaps_on = 1'b0;
      for (p = 0; p < 16 * 9; p++)
         push_item(random_pixel_item(p == 0));
      hold_request <= ~hold_request;
      repeat (64) push_item(read_item(pick_read_index()));
      gaps_on = 1'b1;
      repeat (16) push_item(read_item(pick_read_index()));
   endtask

   initial begin
      source_w_reg = SOURCE_WIDTH_RESET;
      source_h_reg = SOURCE_HEIGHT_RESET;
      fit_geometry();
      restart_position();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_oversized_source();
      test_empty_region();
      test_upscale_skip();
      test_random_frames();
      test_backpressure();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
